FILE: rtl/core/a64_load_store_unit_macros.svh
// Assertion macros for the A64 load/store unit.
// No dependencies.
`ifndef A64_LOAD_STORE_UNIT_MACROS_SVH
`define A64_LOAD_STORE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LSU_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lsu check failed");
// Next-cycle implication checked outside reset.
`define LSU_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lsu check failed");
`endif

FILE: rtl/core/a64lsu_pkg.sv
// Package for the A64 load/store unit: types, constants and item kinds.
// No dependencies.
`timescale 1ns / 1ps
package a64lsu_pkg;
    localparam int MEM_ADDR_BITS_DEF = 16;
    localparam int LIT_BITS = 19;
    localparam int IDX_BITS = 9;
    localparam int NUM_REGS = 31;
    localparam int IN_TDATA_W = 120;
    localparam int OUT_TDATA_W = 160;

    typedef enum logic [2:0] {
        K_EXEC  = 3'd0,
        K_WRMEM = 3'd1,
        K_WRREG = 3'd2,
        K_SETPC = 3'd3,
        K_RDMEM = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_ADDR,
        S_MEM,
        S_MEMWAIT,
        S_WB,
        S_OUT
    } t_state;

    // Sign-extend a 19-bit literal offset times four.
    function automatic logic [63:0] lit_off(input logic [31:0] ins);
        return {{43{ins[23]}}, ins[23:5], 2'b00};
    endfunction
endpackage

FILE: rtl/core/a64lsu_mem.sv
// Byte memory of the A64 load/store unit, one port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module a64lsu_mem #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [MEM_ADDR_BITS-1:0] i_addr,
    input  logic [7:0]               i_wdata,
    output logic [7:0]               o_rdata
);
    logic [7:0] r_mem [2**MEM_ADDR_BITS];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/core/a64_load_store_unit.sv
// Top level of the A64 load/store unit.
// Depends on a64lsu_pkg, a64lsu_mem and a64_load_store_unit_macros.svh.
`timescale 1ns / 1ps
// One item at a time. An executed load/store passes through decode and
// register reads, the shared 64-bit adder that forms base plus offset (and
// the indexed new base), the single byte-wide memory port at one byte per
// cycle (4 or 8 bytes), a wait for the registered read on loads, then
// writeback and output. Memory, register and PC preloads go from decode
// straight to output; a byte readback passes decode, the read wait,
// writeback and output. The result is held in its own output register until
// taken, so the next beat is accepted while it waits; the unit stalls in its
// output state only while that register is full and not being taken.
`include "a64_load_store_unit_macros.svh"
module a64_load_store_unit #(
    parameter int MEM_ADDR_BITS = a64lsu_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[2:0], instruction[34:3], mem_address[50:35], reg_index[55:51],
    // data[119:56]
    input  logic [a64lsu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // is_load[0], access_address[16:1], transfer_value[80:17],
    // base_updated[81], next_pc[145:82], read_byte[153:146], zeros above
    output logic [a64lsu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    localparam int AW = MEM_ADDR_BITS;

    a64lsu_pkg::t_state r_state, n_state;
    logic [63:0] r_regs [a64lsu_pkg::NUM_REGS];
    logic [63:0] r_pc;
    logic [2:0]  r_kind;
    logic [31:0] r_ins;
    logic [AW-1:0] r_maddr;
    logic [4:0]  r_ridx;
    logic [63:0] r_data;
    logic [63:0] r_base, r_opnd, r_stval, r_xfer;
    logic [AW-1:0] r_addr;
    logic [3:0]  r_cnt;
    logic        r_upd, r_load;
    logic [7:0]  r_rbyte;
    logic        r_ovalid;
    logic [a64lsu_pkg::OUT_TDATA_W-1:0] r_out;

    logic [63:0] w_sum;
    logic        w_size8;
    logic        w_we;
    logic [AW-1:0] w_maddr;
    logic [7:0]  w_wdata, w_rdata;
    logic [2:0]  w_bidx;
    logic [2:0]  w_pbidx;

    function automatic logic [63:0] rd(input logic [63:0] regs [a64lsu_pkg::NUM_REGS],
                                       input logic [4:0] idx);
        return (idx == 5'd31) ? 64'd0 : regs[idx];
    endfunction

    assign w_size8 = r_ins[30];
    // Shared adder: base + operand.
    assign w_sum = r_base + r_opnd;
    assign w_bidx = r_cnt[2:0];
    // Byte lane of the read data that arrives this cycle.
    assign w_pbidx = w_bidx - 3'd1;

    always_comb begin
        w_we = 1'b0;
        w_maddr = r_maddr;
        w_wdata = r_data[7:0];
        if (r_state == a64lsu_pkg::S_DEC && r_kind == a64lsu_pkg::K_WRMEM) begin
            w_we = 1'b1;
        end else if (r_state == a64lsu_pkg::S_MEM) begin
            w_maddr = r_addr + AW'(w_bidx);
            w_we = !r_load;
            w_wdata = r_stval[8*w_bidx +: 8];
        end
    end

    a64lsu_mem #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_maddr),
        .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            a64lsu_pkg::S_IDLE:
                if (s_axis_tvalid) n_state = a64lsu_pkg::S_DEC;
            a64lsu_pkg::S_DEC:
                if (r_kind == a64lsu_pkg::K_EXEC) n_state = a64lsu_pkg::S_ADDR;
                else if (r_kind == a64lsu_pkg::K_RDMEM) n_state = a64lsu_pkg::S_MEMWAIT;
                else n_state = a64lsu_pkg::S_OUT;
            a64lsu_pkg::S_ADDR:    n_state = a64lsu_pkg::S_MEM;
            a64lsu_pkg::S_MEM:
                if (r_cnt == (w_size8 ? 4'd7 : 4'd3))
                    n_state = r_load ? a64lsu_pkg::S_MEMWAIT : a64lsu_pkg::S_WB;
            a64lsu_pkg::S_MEMWAIT: n_state = a64lsu_pkg::S_WB;
            a64lsu_pkg::S_WB:      n_state = a64lsu_pkg::S_OUT;
            a64lsu_pkg::S_OUT:
                if (!r_ovalid || m_axis_tready) n_state = a64lsu_pkg::S_IDLE;
            default: n_state = a64lsu_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_axis_tready = (r_state == a64lsu_pkg::S_IDLE);
        m_axis_tvalid = r_ovalid;
    end

    assign m_axis_tdata = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= a64lsu_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_pc <= '0;
            for (int i = 0; i < a64lsu_pkg::NUM_REGS; i++) r_regs[i] <= '0;
        end else begin
            r_state <= n_state;
            // Raise valid when a result moves in, drop it when the beat is taken.
            if (r_state == a64lsu_pkg::S_OUT && (!r_ovalid || m_axis_tready))
                r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                a64lsu_pkg::S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    // Latch the beat.
                    r_kind  <= s_axis_tdata[2:0];
                    r_ins   <= s_axis_tdata[34:3];
                    r_maddr <= AW'(s_axis_tdata[50:35]);
                    r_ridx  <= s_axis_tdata[55:51];
                    r_data  <= s_axis_tdata[119:56];
                    r_cnt   <= '0;
                end
                a64lsu_pkg::S_DEC: begin
                    r_load <= 1'b0; r_upd <= 1'b0; r_xfer <= '0; r_rbyte <= '0;
                    r_addr <= '0;
                    unique case (r_kind)
                        a64lsu_pkg::K_EXEC: begin
                            logic [63:0] st;
                            // Read base, operand and store data before any writeback.
                            st = rd(r_regs, r_ins[4:0]);
                            r_base <= r_ins[31] ? rd(r_regs, r_ins[9:5]) : r_pc;
                            if (!r_ins[31]) r_opnd <= a64lsu_pkg::lit_off(r_ins);
                            else if (r_ins[24])
                                r_opnd <= r_ins[30] ? {49'd0, r_ins[21:10], 3'd0}
                                                    : {50'd0, r_ins[21:10], 2'd0};
                            else if (r_ins[21]) r_opnd <= rd(r_regs, r_ins[20:16]);
                            else r_opnd <= {{55{r_ins[20]}}, r_ins[20:12]};
                            r_stval <= r_ins[30] ? st : {32'd0, st[31:0]};
                            r_load <= !r_ins[31] || r_ins[22];
                        end
                        a64lsu_pkg::K_WRMEM: r_addr <= r_maddr;
                        a64lsu_pkg::K_WRREG:
                            if (r_ridx != 5'd31) r_regs[r_ridx] <= r_data;
                        a64lsu_pkg::K_SETPC: r_pc <= r_data;
                        a64lsu_pkg::K_RDMEM: r_addr <= r_maddr;
                        default: ;
                    endcase
                end
                a64lsu_pkg::S_ADDR: begin
                    // Pre/post-indexed forms write the new base back in full.
                    if (r_ins[31] && !r_ins[24] && !r_ins[21]) begin
                        r_upd <= 1'b1;
                        r_addr <= r_ins[11] ? w_sum[AW-1:0] : r_base[AW-1:0];
                        if (r_ins[9:5] != 5'd31) r_regs[r_ins[9:5]] <= w_sum;
                    end else r_addr <= w_sum[AW-1:0];
                end
                a64lsu_pkg::S_MEM: begin
                    // Advance one byte; load data arrives in the cycle after its address.
                    r_cnt <= r_cnt + 4'd1;
                    if (r_load && r_cnt != 4'd0)
                        r_xfer[8*w_pbidx +: 8] <= w_rdata;
                end
                a64lsu_pkg::S_MEMWAIT: begin
                    if (r_kind == a64lsu_pkg::K_RDMEM) r_rbyte <= w_rdata;
                    else r_xfer[8*w_pbidx +: 8] <= w_rdata;
                end
                a64lsu_pkg::S_WB: begin
                    if (r_kind == a64lsu_pkg::K_EXEC) begin
                        r_pc <= r_pc + 64'd4;
                        if (!r_load) r_xfer <= r_stval;
                        else if (r_ins[4:0] != 5'd31) r_regs[r_ins[4:0]] <= r_xfer;
                    end
                end
                a64lsu_pkg::S_OUT:
                    // Move the result into the output register once it is free.
                    if (!r_ovalid || m_axis_tready)
                        r_out <= {6'd0, r_rbyte, r_pc, r_upd, r_xfer, 16'(r_addr), r_load};
                default: ;
            endcase
        end
    end

    `LSU_ASSERT_IMP(a_ready_not_busy, i_clk, i_rst_n, s_axis_tready, r_state == a64lsu_pkg::S_IDLE)
    `LSU_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_state == a64lsu_pkg::S_MEM, r_cnt < 4'd8)
    `LSU_ASSERT_NXT(a_out_follows, i_clk, i_rst_n, r_state == a64lsu_pkg::S_WB, r_state == a64lsu_pkg::S_OUT)
endmodule
